/* design/m4m_pkg.sv */
package m4m_pkg;

    localparam int DIM        = 4;
    localparam int N_ELEM     = DIM * DIM;
    localparam int IDX_W      = 4;
    localparam int K_W        = 2;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int STEP_W     = 3;

    localparam logic [IDX_W-1:0]  LAST_ELEM      = IDX_W'(N_ELEM - 1);
    localparam logic [STEP_W-1:0] STEP_LAST_READ = STEP_W'(DIM - 1);
    localparam logic [STEP_W-1:0] STEP_FIRST_MUL = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST_MUL  = STEP_W'(DIM);
    localparam logic [STEP_W-1:0] STEP_FIRST_ACC = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_LAST_ACC  = STEP_W'(DIM + 1);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_MULTIPLY   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             load_left;
        logic             load_right;
        logic             op_read;
        logic [K_W-1:0]   k;
        logic [IDX_W-1:0] elem;
        logic             mul_en;
        logic             acc_en;
        logic             acc_first;
        logic             emit;
    } ctl_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

/* design/m4m_cmd_if.sv */
interface m4m_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  element_index;
    logic signed [31:0] element_value;

    modport source (output valid, output opcode, output element_index,
                    output element_value, input ready);
    modport sink   (input valid, input opcode, input element_index,
                    input element_value, output ready);
endinterface

/* design/m4m_res_if.sv */
interface m4m_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  product_index;
    logic signed [31:0] product_value;
    logic        saturated;
    logic        last;

    modport source (output valid, output product_index, output product_value,
                    output saturated, output last, input ready);
    modport sink   (input valid, input product_index, input product_value,
                    input saturated, input last, output ready);
endinterface

/* design/matrix4_multiply_top.sv */
// Fixed-point Q16.16 4x4 matrix multiplier, column-major (index = row + 4*column).
// A load item (left or right element) is written into its matrix when it is
// accepted. A multiply item computes left * right through one shared 32x32
// multiplier, four products per element: each element runs four operand reads,
// the multiply and accumulate drain, and one emit, which waits while the output
// side stalls; no new item is taken until its sixteen results
// are out of the controller. Results come in index order with last on index 15,
// saturated to 32 bits, and replace the left matrix so multiplies chain.
module matrix4_multiply_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    m4m_cmd_if.sink    cmd,
    m4m_res_if.source  res
);

    m4m_pkg::ctl_t    ctl;
    m4m_pkg::status_t status;

    m4m_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .opcode    (cmd.opcode),
        .cmd_ready (cmd.ready),
        .status    (status),
        .ctl       (ctl)
    );

    m4m_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .status     (status),
        .load_index (cmd.element_index),
        .load_value (cmd.element_value),
        .res        (res)
    );

endmodule

/* design/m4m_ctrl.sv */
module m4m_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic [1:0]              opcode,
    output logic                    cmd_ready,
    input  m4m_pkg::status_t        status,
    output m4m_pkg::ctl_t           ctl
);

    m4m_pkg::state_t                   state_reg, state_next;
    logic [m4m_pkg::IDX_W-1:0]         elem_reg, elem_next;
    logic [m4m_pkg::STEP_W-1:0]        step_reg, step_next;
    logic                              accept;

    assign cmd_ready = (state_reg == m4m_pkg::ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= m4m_pkg::ST_IDLE;
            elem_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            m4m_pkg::ST_IDLE:
            begin
                if (accept && m4m_pkg::opcode_t'(opcode) == m4m_pkg::OP_MULTIPLY)
                begin
                    state_next = m4m_pkg::ST_MAC;
                    elem_next  = '0;
                    step_next  = '0;
                end
            end
            m4m_pkg::ST_MAC:
            begin
                if (step_reg == m4m_pkg::STEP_LAST_ACC)
                    state_next = m4m_pkg::ST_EMIT;
                else
                    step_next = step_reg + 1'b1;
            end
            m4m_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    step_next = '0;
                    if (elem_reg == m4m_pkg::LAST_ELEM)
                        state_next = m4m_pkg::ST_IDLE;
                    else
                    begin
                        state_next = m4m_pkg::ST_MAC;
                        elem_next  = elem_reg + 1'b1;
                    end
                end
            end
            default:
                state_next = m4m_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        ctl.elem = elem_reg;
        ctl.k    = step_reg[m4m_pkg::K_W-1:0];
        unique case (state_reg)
            m4m_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (m4m_pkg::opcode_t'(opcode))
                        m4m_pkg::OP_LOAD_LEFT:  ctl.load_left  = 1'b1;
                        m4m_pkg::OP_LOAD_RIGHT: ctl.load_right = 1'b1;
                        default: ;
                    endcase
                end
            end
            m4m_pkg::ST_MAC:
            begin
                ctl.op_read   = (step_reg <= m4m_pkg::STEP_LAST_READ);
                ctl.mul_en    = (step_reg >= m4m_pkg::STEP_FIRST_MUL) &&
                                (step_reg <= m4m_pkg::STEP_LAST_MUL);
                ctl.acc_en    = (step_reg >= m4m_pkg::STEP_FIRST_ACC);
                ctl.acc_first = (step_reg == m4m_pkg::STEP_FIRST_ACC);
            end
            m4m_pkg::ST_EMIT:
                ctl.emit = status.out_free;
            default: ;
        endcase
    end

endmodule

/* design/m4m_datapath.sv */
module m4m_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  m4m_pkg::ctl_t                ctl,
    output m4m_pkg::status_t             status,
    input  logic [m4m_pkg::IDX_W-1:0]    load_index,
    input  logic signed [m4m_pkg::DATA_W-1:0] load_value,
    m4m_res_if.source                    res
);

    localparam int DW = m4m_pkg::DATA_W;
    localparam int AW = m4m_pkg::ACC_W;
    localparam int HI_W = AW - DW + 1;

    logic [DW-1:0]              left_bank_reg [2][m4m_pkg::N_ELEM];
    logic [DW-1:0]              right_reg [m4m_pkg::N_ELEM];
    logic                       sel_reg;
    logic signed [DW-1:0]       a_reg, b_reg;
    logic signed [m4m_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0]       acc_reg, acc_next;
    logic signed [AW-1:0]       shifted;
    logic [HI_W-1:0]            hi_bits;
    logic                       fits;
    logic [DW-1:0]              sat_value;
    logic                       out_valid_reg;
    logic [m4m_pkg::IDX_W-1:0]  out_index_reg;
    logic [DW-1:0]              out_value_reg;
    logic                       out_sat_reg;
    logic                       out_last_reg;
    logic [1:0]                 row, col;
    logic [m4m_pkg::IDX_W-1:0]  left_addr, right_addr;
    logic                       is_last;

    assign row        = ctl.elem[1:0];
    assign col        = ctl.elem[3:2];
    assign left_addr  = {ctl.k, row};
    assign right_addr = {col, ctl.k};
    assign is_last    = (ctl.elem == m4m_pkg::LAST_ELEM);

    assign shifted   = acc_reg >>> FRAC_BITS;
    assign hi_bits   = shifted[AW-1:DW-1];
    assign fits      = (hi_bits == '0) || (hi_bits == '1);
    assign sat_value = fits ? shifted[DW-1:0]
                            : (shifted[AW-1] ? m4m_pkg::SAT_MIN : m4m_pkg::SAT_MAX);

    assign acc_next = ctl.acc_first ? AW'(prod_reg) : acc_reg + AW'(prod_reg);

    assign status.out_free = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
            for (int i = 0; i < m4m_pkg::N_ELEM; i++)
            begin
                left_bank_reg[0][i] <= '0;
                left_bank_reg[1][i] <= '0;
                right_reg[i]        <= '0;
            end
        end
        else
        begin
            if (ctl.load_left)
                left_bank_reg[sel_reg][load_index] <= load_value;
            if (ctl.load_right)
                right_reg[load_index] <= load_value;
            if (ctl.emit)
            begin
                left_bank_reg[!sel_reg][ctl.elem] <= sat_value;
                if (is_last)
                    sel_reg <= !sel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op_read)
        begin
            a_reg <= left_bank_reg[sel_reg][left_addr];
            b_reg <= right_reg[right_addr];
        end
        if (ctl.mul_en)
            prod_reg <= a_reg * b_reg;
        if (ctl.acc_en)
            acc_reg <= acc_next;
        if (ctl.emit)
        begin
            out_index_reg <= ctl.elem;
            out_value_reg <= sat_value;
            out_sat_reg   <= !fits;
            out_last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    assign res.valid         = out_valid_reg;
    assign res.product_index = out_index_reg;
    assign res.product_value = out_value_reg;
    assign res.saturated     = out_sat_reg;
    assign res.last          = out_last_reg;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_BITS = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [65:0] CLIP_HI = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] CLIP_LO = -66'sh0_8000_0000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] value;
        logic               sat;
        logic               last;
    } product_t;

    logic clk;
    logic rst_n;

    m4m_cmd_if cmd_bus ();
    m4m_res_if res_bus ();

    matrix4_multiply_top #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    logic signed [31:0] left_mtx [16];
    logic signed [31:0] right_mtx [16];
    product_t           pending_products [$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic multiply_matrices();
        logic signed [65:0] acc;
        logic signed [63:0] term;
        logic signed [65:0] scaled;
        logic signed [31:0] next_left [16];
        product_t           p;
        int                 e;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                e = r + 4 * c;
                acc = '0;
                for (int k = 0; k < 4; k++)
                begin
                    term = left_mtx[r + 4 * k] * right_mtx[k + 4 * c];
                    acc = acc + term;
                end
                scaled = acc >>> FRAC_BITS;
                p.idx = 4'(e);
                p.last = (e == 15);
                if (scaled > CLIP_HI)
                begin
                    p.value = m4m_pkg::SAT_MAX;
                    p.sat = 1'b1;
                end
                else if (scaled < CLIP_LO)
                begin
                    p.value = m4m_pkg::SAT_MIN;
                    p.sat = 1'b1;
                end
                else
                begin
                    p.value = scaled[31:0];
                    p.sat = 1'b0;
                end
                next_left[e] = p.value;
                pending_products.push_back(p);
            end
        end
        left_mtx = next_left;
    endtask

    task automatic apply_command(input logic [1:0] op, input logic [3:0] idx,
                                 input logic signed [31:0] val);
        case (op)
            m4m_pkg::OP_LOAD_LEFT:  left_mtx[idx] = val;
            m4m_pkg::OP_LOAD_RIGHT: right_mtx[idx] = val;
            m4m_pkg::OP_MULTIPLY:   multiply_matrices();
            default:                ;
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                             input logic signed [31:0] val);
        logic taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.opcode        <= op;
        cmd_bus.element_index <= idx;
        cmd_bus.element_value <= val;
        do
        begin
            @(negedge clk);
            taken = cmd_bus.ready;
            @(posedge clk);
        end
        while (!taken);
        apply_command(op, idx, val);
    endtask

    task automatic wait_all_products();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_products.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_element();
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return m4m_pkg::SAT_MAX;
            3:       return m4m_pkg::SAT_MIN;
            4:       return $urandom_range(1) ? Q_ONE : -Q_ONE;
            5:       return $urandom_range(1) ? 32'sd1 : -32'sd1;
            default: return $signed($urandom_range(32'h0003_FFFF)) - 32'sh0002_0000;
        endcase
    endfunction

    initial
    begin
        product_t got;
        product_t want;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (recv_hold_cycles > 0)
            begin
                res_bus.ready <= 1'b0;
                recv_hold_cycles--;
            end
            else
            begin
                res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(negedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                got.idx   = res_bus.product_index;
                got.value = res_bus.product_value;
                got.sat   = res_bus.saturated;
                got.last  = res_bus.last;
                if (pending_products.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected item index %0d value %h",
                                            got.idx, got.value));
                end
                else
                begin
                    want = pending_products.pop_front();
                    if (got.idx !== want.idx)
                        flag_mismatch($sformatf("product_index %0d, want %0d",
                                                got.idx, want.idx));
                    if (got.value !== want.value)
                        flag_mismatch($sformatf("idx %0d product_value %h, want %h",
                                                want.idx, got.value, want.value));
                    if (got.sat !== want.sat)
                        flag_mismatch($sformatf("idx %0d saturated %b, want %b",
                                                want.idx, got.sat, want.sat));
                    if (got.last !== want.last)
                        flag_mismatch($sformatf("idx %0d last %b, want %b",
                                                want.idx, got.last, want.last));
                end
            end
        end
    end

    task automatic test_multiply_after_reset();
        send_item(m4m_pkg::OP_MULTIPLY, 4'd15, m4m_pkg::SAT_MIN);
    endtask

    task automatic test_unused_opcode();
        send_item(OP_UNUSED, 4'd15, -32'sd1);
        send_item(OP_UNUSED, 4'd0, m4m_pkg::SAT_MAX);
    endtask

    task automatic test_saturation_corners();
        send_item(m4m_pkg::OP_LOAD_LEFT, 4'd0, m4m_pkg::SAT_MIN);
        send_item(m4m_pkg::OP_LOAD_RIGHT, 4'd0, m4m_pkg::SAT_MIN);
        send_item(m4m_pkg::OP_LOAD_LEFT, 4'd15, m4m_pkg::SAT_MAX);
        send_item(m4m_pkg::OP_LOAD_RIGHT, 4'd15, m4m_pkg::SAT_MIN);
        send_item(m4m_pkg::OP_LOAD_RIGHT, 4'd4, 32'sd1);
        send_item(m4m_pkg::OP_LOAD_RIGHT, 4'd8, -32'sd1);
        send_item(m4m_pkg::OP_LOAD_LEFT, 4'd5, -32'sd1);
        send_item(m4m_pkg::OP_LOAD_RIGHT, 4'd5, 32'sd1);
        send_item(m4m_pkg::OP_MULTIPLY, 4'd0, '0);
    endtask

    task automatic test_chained_multiply();
        send_item(m4m_pkg::OP_MULTIPLY, 4'd7, 32'sh1234_5678);
    endtask

    task automatic test_full_width_sum();
        for (int k = 0; k < 4; k++)
        begin
            send_item(m4m_pkg::OP_LOAD_LEFT, 4'(4 * k), m4m_pkg::SAT_MIN);
            send_item(m4m_pkg::OP_LOAD_RIGHT, 4'(k), m4m_pkg::SAT_MIN);
        end
        send_item(m4m_pkg::OP_MULTIPLY, 4'd0, '0);
    endtask

    task automatic test_pressure();
        recv_hold_cycles = 600;
        send_item(m4m_pkg::OP_MULTIPLY, 4'd0, '0);
        for (int i = 0; i < 6; i++)
            send_item(i[0] ? m4m_pkg::OP_LOAD_RIGHT : m4m_pkg::OP_LOAD_LEFT,
                      4'($urandom_range(15)), pick_element());
        send_item(m4m_pkg::OP_MULTIPLY, 4'd0, '0);
        wait_all_products();
    endtask

    task automatic test_random_sequences(input int n_items, input int send_pct,
                                         input int recv_pct);
        int sent;
        int n_loads;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item($urandom_range(1) ? OP_UNUSED : m4m_pkg::OP_MULTIPLY,
                          4'($urandom_range(15)), $urandom);
                sent++;
            end
            else
            begin
                n_loads = $urandom_range(1, 20);
                for (int i = 0; i < n_loads; i++)
                    send_item($urandom_range(1) ? m4m_pkg::OP_LOAD_RIGHT
                                                : m4m_pkg::OP_LOAD_LEFT,
                              4'($urandom_range(15)), pick_element());
                send_item(m4m_pkg::OP_MULTIPLY, 4'($urandom_range(15)), $urandom);
                sent += n_loads + 1;
            end
        end
    endtask

    initial
    begin
        error_count      = 0;
        recv_hold_cycles = 0;
        send_idle_pct    = 34;
        recv_idle_pct    = 77;
        for (int i = 0; i < 16; i++)
        begin
            left_mtx[i]  = '0;
            right_mtx[i] = '0;
        end
        rst_n                 <= 1'b0;
        cmd_bus.valid         <= 1'b0;
        cmd_bus.opcode        <= m4m_pkg::OP_LOAD_LEFT;
        cmd_bus.element_index <= '0;
        cmd_bus.element_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_multiply_after_reset();
        test_unused_opcode();
        test_saturation_corners();
        test_chained_multiply();
        test_full_width_sum();
        test_pressure();
        test_random_sequences(80, 34, 77);
        test_random_sequences(80, 77, 34);
        test_random_sequences(80, 0, 0);

        wait_all_products();
        repeat (20) @(posedge clk);
        if (pending_products.size() != 0)
            flag_mismatch($sformatf("%0d items never arrived", pending_products.size()));
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
